// File: hdl/swlv_pkg.sv
// ----------------------------------------------------------------------------
// swlv_pkg: shared types for the sliding window label vote unit
// holds the controller states, the command and status bundles and fixed widths
// ----------------------------------------------------------------------------
package swlv_pkg;

  localparam int LABEL_W      = 4;
  localparam int VOTES_W      = 5;
  localparam int NUM_LABELS_W = 5;

  localparam logic [NUM_LABELS_W-1:0] NUM_LABELS_RST = 5'd16;
  localparam logic [VOTES_W-1:0]      VOTES_SAT      = 5'd31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVICT,
    ST_DEC,
    ST_INC,
    ST_SCAN,
    ST_LAST,
    ST_LOAD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;     // latch the new label, read the ring slot
    logic evict;       // write ring, advance slot, read evicted label's count
    logic dec;         // write back decremented count, read new label's count
    logic inc;         // write back incremented count, clear scan index
    logic scan_issue;  // read one counter for the winner search
    logic load;        // move the winner into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;   // current scan read is the last class
    logic out_free;    // output register can take a new beat
  } sts_t;

endpackage

// File: hdl/swlv_ctrl.sv
// ----------------------------------------------------------------------------
// swlv_ctrl: sequencer of the label vote unit
// steps one label through evict, count update, winner scan and output load
// ----------------------------------------------------------------------------
module swlv_ctrl
  import swlv_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_stall,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state, state_next;
  logic   accept;

  assign accept = in_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_EVICT;
      ST_EVICT: state_next = ST_DEC;
      ST_DEC:   state_next = ST_INC;
      ST_INC:   state_next = ST_SCAN;
      ST_SCAN:  if (sts.scan_last) state_next = ST_LAST;
      ST_LAST:  state_next = ST_LOAD;
      ST_LOAD:  if (sts.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = accept;
      end
      ST_EVICT: cmd.evict      = 1'b1;
      ST_DEC:   cmd.dec        = 1'b1;
      ST_INC:   cmd.inc        = 1'b1;
      ST_SCAN:  cmd.scan_issue = 1'b1;
      ST_LAST:  cmd            = '0;
      ST_LOAD:  cmd.load       = sts.out_free;
      default:  cmd            = '0;
    endcase
  end

  a_accept_starts_evict: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == ST_EVICT)
    else $error("accepted beat did not start the evict step");

  a_load_waits: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD && !sts.out_free |=> state == ST_LOAD)
    else $error("left load while the output register was full");

  a_stall_when_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> in_stall)
    else $error("input open while a beat is in progress");

endmodule

// File: hdl/swlv_dpath.sv
// ----------------------------------------------------------------------------
// swlv_dpath: datapath of the label vote unit
// label ring memory, vote counter memory, winner compare and output register
// ----------------------------------------------------------------------------
module swlv_dpath
  import swlv_pkg::*;
#(
  parameter int WINDOW_LEN = 16,
  parameter int MAX_LABELS = 16
)(
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic                    cfg_we,
  input  logic [NUM_LABELS_W-1:0] cfg_wdata,
  input  logic [LABEL_W-1:0]      label,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [LABEL_W-1:0]      winner_label,
  output logic [VOTES_W-1:0]      winner_votes
);

  localparam int RAW  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int VW   = $clog2(WINDOW_LEN + 1);
  // labels are 4 bits wide, so at most 16 classes can ever hold votes
  localparam int NCNT = (MAX_LABELS < 16) ? MAX_LABELS : 16;
  localparam int CAW  = $clog2(NCNT);
  localparam int SIW  = CAW + 1;

  localparam logic [RAW-1:0]          RING_LAST = RAW'(WINDOW_LEN - 1);
  localparam logic [8:0]              MAX_L9    = 9'(MAX_LABELS);
  localparam logic [NUM_LABELS_W-1:0] NCNT_N    = NUM_LABELS_W'(NCNT);
  localparam logic [VW-1:0]           VOTES_MAX = VW'(WINDOW_LEN);

  // configuration
  logic [NUM_LABELS_W-1:0] num_labels;
  logic [NUM_LABELS_W-1:0] scan_n;

  // ring
  logic [LABEL_W-1:0] ring_mem [WINDOW_LEN];
  logic [RAW-1:0]     slot;
  logic               full;
  logic [LABEL_W-1:0] lab_q;
  logic [LABEL_W-1:0] old_q;
  logic               do_dec, do_inc;
  logic               do_dec_next, do_inc_next;

  // counters
  logic [VW-1:0]  cnt_mem [NCNT];
  logic [NCNT-1:0] cnt_vld;
  logic [VW-1:0]  cnt_rd_q;
  logic [CAW-1:0] cnt_raddr;
  logic [CAW-1:0] cnt_waddr;
  logic [VW-1:0]  cnt_wdata;
  logic           cnt_we;

  // winner search
  logic [SIW-1:0] scan_idx;
  logic           cmp_vld;
  logic [CAW-1:0] cmp_idx;
  logic [VW-1:0]  best_cnt;
  logic [CAW-1:0] best_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_labels <= NUM_LABELS_RST;
    end else if (cfg_we) begin
      num_labels <= cfg_wdata;
    end
  end

  // classes clamped to 1 .. counters that exist
  always_comb begin
    if (num_labels == '0) begin
      scan_n = NUM_LABELS_W'(1);
    end else if (num_labels > NCNT_N) begin
      scan_n = NCNT_N;
    end else begin
      scan_n = num_labels;
    end
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lab_q <= label;
      old_q <= ring_mem[slot];
    end
    if (cmd.evict) begin
      ring_mem[slot] <= lab_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      full <= 1'b0;
    end else if (cmd.evict) begin
      if (slot == RING_LAST) begin
        slot <= '0;
        full <= 1'b1;
      end else begin
        slot <= slot + RAW'(1);
      end
    end
  end

  // same label in and out leaves its count alone
  always_comb begin
    do_dec_next = full && ({5'd0, old_q} < MAX_L9) && (old_q != lab_q);
    do_inc_next = ({5'd0, lab_q} < MAX_L9) && !(full && (old_q == lab_q));
  end

  always_ff @(posedge clk) begin
    if (cmd.evict) begin
      do_dec <= do_dec_next;
      do_inc <= do_inc_next;
    end
  end

  // counter memory port
  always_comb begin
    if (cmd.evict) begin
      cnt_raddr = old_q[CAW-1:0];
    end else if (cmd.dec) begin
      cnt_raddr = lab_q[CAW-1:0];
    end else begin
      cnt_raddr = scan_idx[CAW-1:0];
    end
    cnt_we    = 1'b0;
    cnt_waddr = lab_q[CAW-1:0];
    cnt_wdata = cnt_rd_q + VW'(1);
    if (cmd.dec) begin
      cnt_we    = do_dec;
      cnt_waddr = old_q[CAW-1:0];
      cnt_wdata = (cnt_rd_q != '0) ? cnt_rd_q - VW'(1) : '0;
    end else if (cmd.inc) begin
      cnt_we = do_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd_q <= cnt_vld[cnt_raddr] ? cnt_mem[cnt_raddr] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld <= '0;
    end else if (cnt_we) begin
      cnt_vld[cnt_waddr] <= 1'b1;
    end
  end

  // scan reads one counter a cycle, compared in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      cmp_vld  <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan_issue;
      if (cmd.inc) begin
        scan_idx <= '0;
      end else if (cmd.scan_issue) begin
        scan_idx <= scan_idx + SIW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_issue) begin
      cmp_idx <= scan_idx[CAW-1:0];
    end
    if (cmp_vld && ((cmp_idx == '0) || (cnt_rd_q > best_cnt))) begin
      best_cnt <= cnt_rd_q;
      best_idx <= cmp_idx;
    end
  end

  assign sts.scan_last = (NUM_LABELS_W'(scan_idx) == scan_n - NUM_LABELS_W'(1));
  assign sts.out_free  = !out_valid || !out_stall;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      winner_label <= LABEL_W'(best_idx);
      winner_votes <= (32'(best_cnt) > 32'(VOTES_SAT)) ? VOTES_SAT : VOTES_W'(best_cnt);
    end
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_issue |-> NUM_LABELS_W'(scan_idx) < scan_n)
    else $error("scan read beyond the active classes");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    cnt_we |-> cnt_wdata <= VOTES_MAX)
    else $error("vote count above window length");

  a_load_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_issue && sts.scan_last |=> ##1 !cmp_vld)
    else $error("compare still running after the last scan read");

endmodule

// File: hdl/sliding_window_label_vote_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_label_vote_unit: sliding-window majority vote over labels
// smooths classifier labels; reports the most frequent label in the window
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_stall   label[3:0]
//  output    out        out_valid / out_stall winner_label[3:0], winner_votes[4:0]
//  config    in         cfg_we                cfg_wdata[4:0] (num_labels)
//
//  the winner scan reads the counter memory's single read port once per class,
//  for N classes, N = num_labels clamped to 1 .. classes, so the time that one
//  beat takes in the unit grows with N
//  the next beat is taken while a finished result waits in the output register
//  a stalled output holds the controller in its load step until the beat leaves
//  reset is synchronous: clears vote valid bits, ring pointer, fill flag,
//  num_labels (to 16) and the output valid; ring contents need no reset
//
module sliding_window_label_vote_unit
  import swlv_pkg::*;
#(
  parameter int WINDOW_LEN = 16,
  parameter int MAX_LABELS = 16
)(
  input  logic                    clk,
  input  logic                    rst,
  // config
  input  logic                    cfg_we,
  input  logic [NUM_LABELS_W-1:0] cfg_wdata,
  // input beats
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [LABEL_W-1:0]      label,
  // output beats
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [LABEL_W-1:0]      winner_label,
  output logic [VOTES_W-1:0]      winner_votes
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: evict, decrement, increment, scan, load
  swlv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // ring, counters, winner compare and output register
  swlv_dpath #(
    .WINDOW_LEN (WINDOW_LEN),
    .MAX_LABELS (MAX_LABELS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .label        (label),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .winner_label (winner_label),
    .winner_votes (winner_votes)
  );

endmodule

// File: tb/sliding_window_label_vote_unit_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_label_vote_unit_tb: self-checking bench for the label vote unit
// drives label beats in random bursts against a stalling receiver, predicts the
// window winner for every accepted beat and checks each result in order
// ----------------------------------------------------------------------------
module sliding_window_label_vote_unit_tb
  import swlv_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_LEN  = 16;
  localparam int MAX_LABELS  = 16;
  localparam int QUIET_LIMIT = 4000;  // cycles with no beat on either side
  localparam int DRAIN_WAIT  = 40;    // settle wait after the last phase
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int PHASE_BEATS = 55;
  localparam int MAX_REPORTS = 10;

  // receiver stall patterns
  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_t;

  // one result beat as the block should produce it
  typedef struct packed {
    logic [LABEL_W-1:0] lbl;
    logic [VOTES_W-1:0] votes;
  } winner_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [NUM_LABELS_W-1:0] cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [LABEL_W-1:0]      label = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [LABEL_W-1:0]      winner_label;
  logic [VOTES_W-1:0]      winner_votes;

  sliding_window_label_vote_unit #(
    .WINDOW_LEN(WINDOW_LEN),
    .MAX_LABELS(MAX_LABELS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .label       (label),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .winner_label(winner_label),
    .winner_votes(winner_votes)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // vote predictor: private copy of the ring, the counters and num_labels
  // --------------------------------------------------------------------------
  logic [LABEL_W-1:0]      hist_labels [WINDOW_LEN];
  int                      hist_votes  [MAX_LABELS];
  int                      hist_slot;
  int                      hist_fill;
  logic [NUM_LABELS_W-1:0] classes_reg;

  function automatic void clear_history();
    for (int k = 0; k < WINDOW_LEN; k++) hist_labels[k] = '0;
    for (int k = 0; k < MAX_LABELS; k++) hist_votes[k] = 0;
    hist_slot   = 0;
    hist_fill   = 0;
    classes_reg = NUM_LABELS_RST;
  endfunction

  // push one label into the window and return the winner that follows
  function automatic winner_t predict_winner(logic [LABEL_W-1:0] lab);
    int      gone;
    int      classes;
    int      best;
    winner_t w;
    if (hist_fill >= WINDOW_LEN) begin
      // window full: the oldest label leaves, label 0 included
      gone = int'(hist_labels[hist_slot]);
      if (gone < MAX_LABELS && hist_votes[gone] > 0) hist_votes[gone]--;
    end else begin
      hist_fill++;
    end
    hist_labels[hist_slot] = lab;
    if (lab < MAX_LABELS) hist_votes[lab]++;
    hist_slot = (hist_slot + 1) % WINDOW_LEN;

    // class count out of range is clamped to 1 .. MAX_LABELS
    classes = int'(classes_reg);
    if (classes < 1) classes = 1;
    if (classes > MAX_LABELS) classes = MAX_LABELS;

    // strict greater-than keeps the lowest index on a tie
    best = 0;
    for (int k = 1; k < classes; k++) begin
      if (hist_votes[k] > hist_votes[best]) best = k;
    end
    w.lbl   = best[LABEL_W-1:0];
    w.votes = (hist_votes[best] > VOTES_SAT) ? VOTES_SAT : hist_votes[best][VOTES_W-1:0];
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // bookkeeping shared by the stimulus, the driver and the monitor
  // --------------------------------------------------------------------------
  logic [LABEL_W-1:0] label_backlog [$];  // labels not yet offered
  winner_t            winner_q [$];       // predicted results, oldest first
  winner_t            want;
  int                 labels_queued = 0;
  int                 winners_seen  = 0;
  int                 mismatches    = 0;
  logic               in_fire = 1'b0;     // input beat taken at the last rising edge
  logic               hold_req = 1'b0;    // ask the receiver for one long hold-off

  // --------------------------------------------------------------------------
  // input driver: bursts of beats with random gaps, changes on the falling edge
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // stalled beat: payload stays put
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (label_backlog.size() > 0) begin
      in_valid <= 1'b1;
      label    <= label_backlog.pop_front();
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        // end of burst: pick the next gap, sometimes none at all
        burst_left = $urandom_range(1, 30);
        case ($urandom_range(0, 3))
          0:       gap_left = 0;
          1:       gap_left = $urandom_range(1, 3);
          2:       gap_left = $urandom_range(1, 30);
          default: gap_left = $urandom_range(1, 60);
        endcase
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // receiver stall: random stretches of stall patterns, plus one long hold-off
  // --------------------------------------------------------------------------
  rx_mode_t rx_mode    = RX_FREE;
  int       mode_left  = 0;
  int       hold_left  = 0;
  logic     hold_taken = 1'b0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req && !hold_taken) begin
      // sender keeps offering while this runs, so the block backs up
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HALF:  out_stall <= 1'($urandom_range(0, 1));
        default:  out_stall <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predict on each input beat, check each output beat in order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_fire = 1'b0;
    if (rst) begin
      clear_history();
    end else begin
      if (cfg_we) classes_reg = cfg_wdata;
      if (in_valid && !in_stall) begin
        in_fire = 1'b1;
        winner_q.push_back(predict_winner(label));
      end
      if (out_valid && !out_stall) begin
        winners_seen++;
        if (winner_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected beat label=%0d votes=%0d",
                     $realtime, winner_label, winner_votes);
        end else begin
          want = winner_q.pop_front();
          if (want.lbl !== winner_label || want.votes !== winner_votes) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: beat %0d label exp %0d got %0d, votes exp %0d got %0d",
                       $realtime, winners_seen, want.lbl, winner_label,
                       want.votes, winner_votes);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long with no beat on either side ends the run
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic queue_label(logic [LABEL_W-1:0] lab);
    label_backlog.push_back(lab);
    labels_queued++;
  endtask

  // classifier-like traffic: steady runs with noise, tie makers, pure noise
  task automatic queue_random_labels(int count);
    int                 made;
    int                 len;
    logic [LABEL_W-1:0] a;
    logic [LABEL_W-1:0] b;
    made = 0;
    while (made < count) begin
      a = LABEL_W'($urandom_range(0, 15));
      b = LABEL_W'($urandom_range(0, 15));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // steady run of one label, sprinkled with misclassifications
          len = $urandom_range(1, 20);
          for (int k = 0; k < len && made < count; k++) begin
            queue_label(($urandom_range(0, 6) == 0) ? LABEL_W'($urandom_range(0, 15)) : a);
            made++;
          end
        end
        6, 7: begin
          // two labels taking turns, so counts keep tying
          len = $urandom_range(2, 16);
          for (int k = 0; k < len && made < count; k++) begin
            queue_label(k[0] ? b : a);
            made++;
          end
        end
        default: begin
          len = $urandom_range(1, 10);
          for (int k = 0; k < len && made < count; k++) begin
            queue_label(LABEL_W'($urandom_range(0, 15)));
            made++;
          end
        end
      endcase
    end
  endtask

  // wait until every queued label has come back as a result
  task automatic wait_drained();
    wait (winners_seen >= labels_queued);
  endtask

  // block is idle here: nothing queued, nothing in flight
  task automatic write_num_labels(logic [NUM_LABELS_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [NUM_LABELS_W-1:0] class_plan [$];

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset value of num_labels (16 classes):
    // both label extremes, a two-way tie, then fill the window
    queue_label(4'd0);
    queue_label(4'd15);
    queue_label(4'd15);
    queue_label(4'd0);
    for (int k = 0; k < 12; k++) queue_label(4'd5);
    // window full: label 0 leaves while label 0 enters (same label in and out),
    // then label 15 leaves, then label 15 leaves again and comes back
    queue_label(4'd0);
    queue_label(4'd7);
    queue_label(4'd15);
    wait_drained();

    // class count extremes first (0 acts as 1, 31 as 16), then random settings
    class_plan = '{5'd0, 5'd31, 5'd1, 5'd17, 5'd16};
    for (int k = 0; k < 6; k++) class_plan.push_back(NUM_LABELS_W'($urandom_range(0, 31)));

    for (int p = 0; p < class_plan.size(); p++) begin
      write_num_labels(class_plan[p]);
      queue_random_labels(PHASE_BEATS);
      // one phase runs against a receiver that holds off for a long stretch
      if (p == 7) hold_req = 1'b1;
      wait_drained();
    end

    // settle: anything still coming out now is unexpected
    repeat (DRAIN_WAIT) @(posedge clk);
    if (winner_q.size() != 0) begin
      $display("%0d predicted results never arrived", winner_q.size());
      mismatches += winner_q.size();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/swlv_pkg.sv
hdl/swlv_ctrl.sv
hdl/swlv_dpath.sv
hdl/sliding_window_label_vote_unit.sv
tb/sliding_window_label_vote_unit_tb.sv
